@@ src/hged_pkg.sv @@
// hged_pkg: fixed constants for the hexagonal edge distance pipeline.
// No dependencies; used by hex_grid_edge_distance.
`timescale 1ns / 1ps
`default_nettype none

package hged_pkg;

  // Coordinate width of the input fields (two's complement).
  localparam int unsigned IN_W = 24;

  // sqrt(3) rounded to 30 fraction bits.
  localparam int unsigned SQ_W = 31;
  localparam logic [SQ_W-1:0] SQRT3_Q30 = 31'd1859775393;

  // Shift that places sqrt(3) products back on the input grid.
  localparam int unsigned SQ_FRAC = 30;

  // Number of register stages from input transfer to output register.
  localparam int unsigned N_STAGES = 12;

endpackage : hged_pkg

`default_nettype wire

@@ src/hex_grid_edge_distance.sv @@
// hex_grid_edge_distance: twelve-stage pipeline giving the distance from a point to
// the nearest edge of a hexagonal tiling. Depends on hged_pkg.
`timescale 1ns / 1ps
`default_nettype none

// The block takes one point (x, y) per transfer, both signed Q.FRAC_BITS in 24
// bits, and returns one unsigned Q.FRAC_BITS distance (at most 1.5) per point.
// It is a twelve-stage pipeline: out_valid rises when the point reaches the
// stage 12 output register. While out_ready stays high and so the output side
// never stalls, a new point can enter every
// clock, so the sustained rate is one point per cycle. Every stage has its own
// valid bit and a load enable that is set when the stage is empty or the stage
// after it moves, so idle stages fill up while the output waits; in_ready drops
// only when all twelve stages hold an item and out_ready is low. The longest
// path per stage is one multiplier (at most about 25 x 31 bits at the widest
// FRAC_BITS) or one wide subtract and compare. The block keeps no state beyond
// the pipeline and needs no configuration.
module hex_grid_edge_distance #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [hged_pkg::IN_W-1:0]     in_x_coord,
  input  logic signed [hged_pkg::IN_W-1:0]     in_y_coord,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic        [FRAC_BITS:0]            out_edge_distance
);

  // ---------------------------------------------------------------------------
  // Elaboration-time constants
  // ---------------------------------------------------------------------------
  localparam int unsigned IW  = hged_pkg::IN_W;
  localparam int unsigned F   = FRAC_BITS;
  localparam int unsigned NST = hged_pkg::N_STAGES;
  localparam int unsigned OW  = F + 1;

  // Residue width: mod_y = 3 * 2^F needs F+2 bits.
  localparam int unsigned MW  = F + 2;
  // Working width for the residue subtract.
  localparam int unsigned CW  = (IW > MW) ? IW : MW;
  // Reciprocal / quotient width, reciprocal < 2^(IW-F).
  localparam int unsigned RW  = IW - F + 1;
  // Product width of the sqrt(3) stage.
  localparam int unsigned PW  = F + hged_pkg::SQ_W + 1;
  // Sum of squares width.
  localparam int unsigned SW  = 2 * F + 3;

  localparam longint unsigned SQ_L    = longint'(hged_pkg::SQRT3_Q30);
  localparam longint unsigned HALF_R3 = (SQ_L + (64'd1 << (30 - F))) >> (31 - F);
  localparam longint unsigned MOD_X   = 2 * HALF_R3;
  localparam longint unsigned MOD_Y   = 64'd3 << F;
  localparam longint unsigned HALF_Y  = 64'd3 << (F - 1);
  // floor(2^IW / mod): quotient estimate is exact or one low.
  localparam longint unsigned RECIP_X = (64'd1 << IW) / MOD_X;
  localparam longint unsigned RECIP_Y = (64'd1 << IW) / MOD_Y;

  localparam logic [RW-1:0] RX_R   = RW'(RECIP_X);
  localparam logic [RW-1:0] RY_R   = RW'(RECIP_Y);
  localparam logic [MW-1:0] MOD_XM = MW'(MOD_X);
  localparam logic [MW-1:0] MOD_YM = MW'(MOD_Y);
  localparam logic [CW-1:0] MOD_XC = CW'(MOD_X);
  localparam logic [CW-1:0] MOD_YC = CW'(MOD_Y);
  localparam logic [MW-1:0] HR3_M  = MW'(HALF_R3);
  localparam logic [MW-1:0] HY_M   = MW'(HALF_Y);
  localparam logic [F-1:0]  HR3_X  = F'(HALF_R3);
  localparam logic [F:0]    HY_Y   = (F + 1)'(HALF_Y);
  localparam logic [F+1:0]  HY_S   = (F + 2)'(HALF_Y);
  localparam logic [PW:0]   RND    = (PW + 1)'(1) << hged_pkg::SQ_FRAC;

  // ---------------------------------------------------------------------------
  // Pipeline control: per-stage valid and load enable
  // ---------------------------------------------------------------------------
  logic [NST-1:0] v_r;
  logic [NST-1:0] v_nxt;
  logic [NST-1:0] en;

  always_comb begin
    en[NST-1] = ~v_r[NST-1] | out_ready;
    for (int i = NST - 2; i >= 0; i--) begin
      en[i] = ~v_r[i] | en[i+1];
    end
    for (int i = 0; i < NST; i++) begin
      if (en[i]) begin
        v_nxt[i] = (i == 0) ? in_valid : v_r[(i == 0) ? 0 : i - 1];
      end else begin
        v_nxt[i] = v_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[0];
  assign out_valid = v_r[NST-1];

  // ---------------------------------------------------------------------------
  // Stage 1: magnitudes (the most negative code maps to 2^23, still 24 bits)
  // ---------------------------------------------------------------------------
  logic [IW-1:0] s1_ax_r, s1_ay_r;
  logic [IW-1:0] s1_ax_nxt, s1_ay_nxt;

  always_comb begin
    s1_ax_nxt = in_x_coord[IW-1] ? ($unsigned(~in_x_coord) + IW'(1)) : $unsigned(in_x_coord);
    s1_ay_nxt = in_y_coord[IW-1] ? ($unsigned(~in_y_coord) + IW'(1)) : $unsigned(in_y_coord);
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1_ax_r <= s1_ax_nxt;
      s1_ay_r <= s1_ay_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: quotient estimate by reciprocal multiply
  // ---------------------------------------------------------------------------
  logic [IW-1:0]    s2_ax_r, s2_ay_r;
  logic [RW-1:0]    s2_qx_r, s2_qy_r;
  logic [IW+RW-1:0] s2_px_nxt, s2_py_nxt;

  always_comb begin
    s2_px_nxt = (IW + RW)'(s1_ax_r) * (IW + RW)'(RX_R);
    s2_py_nxt = (IW + RW)'(s1_ay_r) * (IW + RW)'(RY_R);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s2_ax_r <= s1_ax_r;
      s2_ay_r <= s1_ay_r;
      s2_qx_r <= s2_px_nxt[IW+RW-1:IW];
      s2_qy_r <= s2_py_nxt[IW+RW-1:IW];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: quotient times modulus (never exceeds the magnitude)
  // ---------------------------------------------------------------------------
  logic [IW-1:0]    s3_ax_r, s3_ay_r;
  logic [CW-1:0]    s3_mx_r, s3_my_r;
  logic [RW+MW-1:0] s3_mx_nxt, s3_my_nxt;

  always_comb begin
    s3_mx_nxt = (RW + MW)'(s2_qx_r) * (RW + MW)'(MOD_XM);
    s3_my_nxt = (RW + MW)'(s2_qy_r) * (RW + MW)'(MOD_YM);
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      s3_ax_r <= s2_ax_r;
      s3_ay_r <= s2_ay_r;
      s3_mx_r <= s3_mx_nxt[CW-1:0];
      s3_my_r <= s3_my_nxt[CW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: raw residue, in [0, 2*mod)
  // ---------------------------------------------------------------------------
  logic [CW-1:0] s4_rx_r, s4_ry_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s4_rx_r <= CW'(s3_ax_r) - s3_mx_r;
      s4_ry_r <= CW'(s3_ay_r) - s3_my_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: one correction step gives the exact residue
  // ---------------------------------------------------------------------------
  logic [MW-1:0] s5_rx_r, s5_ry_r;
  logic [CW-1:0] s5_rx_nxt, s5_ry_nxt;

  always_comb begin
    s5_rx_nxt = (s4_rx_r >= MOD_XC) ? (s4_rx_r - MOD_XC) : s4_rx_r;
    s5_ry_nxt = (s4_ry_r >= MOD_YC) ? (s4_ry_r - MOD_YC) : s4_ry_r;
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s5_rx_r <= s5_rx_nxt[MW-1:0];
      s5_ry_r <= s5_ry_nxt[MW-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 6: center the residue and take its magnitude
  // ---------------------------------------------------------------------------
  logic [F-1:0]  s6_x1_r;
  logic [F:0]    s6_y1_r;
  logic [MW-1:0] s6_dx_nxt, s6_dy_nxt;

  always_comb begin
    s6_dx_nxt = (s5_rx_r >= HR3_M) ? (s5_rx_r - HR3_M) : (HR3_M - s5_rx_r);
    s6_dy_nxt = (s5_ry_r >= HY_M) ? (s5_ry_r - HY_M) : (HY_M - s5_ry_r);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s6_x1_r <= s6_dx_nxt[F-1:0];
      s6_y1_r <= s6_dy_nxt[F:0];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: partner point relative to the other lattice center
  // ---------------------------------------------------------------------------
  logic [F-1:0] s7_x1_r, s7_x2_r;
  logic [F:0]   s7_y1_r, s7_y2_r;

  always_ff @(posedge clk) begin
    if (en[6]) begin
      s7_x1_r <= s6_x1_r;
      s7_y1_r <= s6_y1_r;
      s7_x2_r <= HR3_X - s6_x1_r;
      s7_y2_r <= HY_Y - s6_y1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 8: squared components of both candidates
  // ---------------------------------------------------------------------------
  logic [F-1:0]   s8_x1_r, s8_x2_r;
  logic [F:0]     s8_y1_r, s8_y2_r;
  logic [2*F-1:0] s8_x1sq_r, s8_x2sq_r;
  logic [2*F+1:0] s8_y1sq_r, s8_y2sq_r;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s8_x1_r   <= s7_x1_r;
      s8_x2_r   <= s7_x2_r;
      s8_y1_r   <= s7_y1_r;
      s8_y2_r   <= s7_y2_r;
      s8_x1sq_r <= (2 * F)'(s7_x1_r) * (2 * F)'(s7_x1_r);
      s8_x2sq_r <= (2 * F)'(s7_x2_r) * (2 * F)'(s7_x2_r);
      s8_y1sq_r <= (2 * F + 2)'(s7_y1_r) * (2 * F + 2)'(s7_y1_r);
      s8_y2sq_r <= (2 * F + 2)'(s7_y2_r) * (2 * F + 2)'(s7_y2_r);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 9: keep the nearer center; ties keep the first candidate
  // ---------------------------------------------------------------------------
  logic [F-1:0]  s9_x_r;
  logic [F:0]    s9_y_r;
  logic [SW-1:0] s9_d1_nxt, s9_d2_nxt;
  logic          s9_swap_nxt;

  always_comb begin
    s9_d1_nxt   = SW'(s8_x1sq_r) + SW'(s8_y1sq_r);
    s9_d2_nxt   = SW'(s8_x2sq_r) + SW'(s8_y2sq_r);
    s9_swap_nxt = s9_d1_nxt > s9_d2_nxt;
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      s9_x_r <= s9_swap_nxt ? s8_x2_r : s8_x1_r;
      s9_y_r <= s9_swap_nxt ? s8_y2_r : s8_y1_r;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 10: sqrt(3) products for the 30 degree test and slanted edge
  // ---------------------------------------------------------------------------
  logic [F-1:0]  s10_x_r;
  logic [F:0]    s10_y_r;
  logic [PW-1:0] s10_py_r;
  logic [PW-2:0] s10_px_r;

  always_ff @(posedge clk) begin
    if (en[9]) begin
      s10_x_r  <= s9_x_r;
      s10_y_r  <= s9_y_r;
      s10_py_r <= PW'(s9_y_r) * PW'(hged_pkg::SQRT3_Q30);
      s10_px_r <= (PW - 1)'(s9_x_r) * (PW - 1)'(hged_pkg::SQRT3_Q30);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 11: branch flag and both signs of the slanted difference
  // ---------------------------------------------------------------------------
  logic [F:0]    s11_y_r;
  logic          s11_low_r;
  logic          s11_ge_r;
  logic [PW-1:0] s11_dpos_r, s11_dneg_r;
  logic [PW-1:0] s11_xl_nxt, s11_yl_nxt, s11_px_nxt;

  always_comb begin
    s11_xl_nxt = {2'b00, s10_x_r, {hged_pkg::SQ_FRAC{1'b0}}};
    s11_yl_nxt = {1'b0, s10_y_r, {hged_pkg::SQ_FRAC{1'b0}}};
    s11_px_nxt = {1'b0, s10_px_r};
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      s11_y_r    <= s10_y_r;
      s11_low_r  <= s10_py_r < s11_xl_nxt;
      s11_ge_r   <= s11_yl_nxt >= s11_px_nxt;
      s11_dpos_r <= s11_yl_nxt - s11_px_nxt;
      s11_dneg_r <= s11_px_nxt - s11_yl_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 12: output register - round, saturate, pick the branch
  // ---------------------------------------------------------------------------
  logic [OW-1:0] s12_dist_r;
  logic [PW:0]   s12_sum_nxt;
  logic [F+1:0]  s12_res_nxt;
  logic [OW-1:0] s12_dist_nxt;

  always_comb begin
    s12_sum_nxt = (PW + 1)'(s11_ge_r ? s11_dpos_r : s11_dneg_r) + RND;
    s12_res_nxt = s12_sum_nxt[PW:31];
    if (s11_low_r) begin
      s12_dist_nxt = s11_y_r;
    end else if (s12_res_nxt > HY_S) begin
      s12_dist_nxt = HY_Y;
    end else begin
      s12_dist_nxt = s12_res_nxt[F:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      s12_dist_r <= s12_dist_nxt;
    end
  end

  assign out_edge_distance = s12_dist_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef ASSERT_OFF
  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> v_r[0])
    else $error("input transfer did not fill stage 1");

  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&v_r) && !out_ready)
    else $error("input stalled while the pipeline had room");

  a_residue: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> (s5_rx_r < MOD_XM) && (s5_ry_r < MOD_YM))
    else $error("fold residue out of range");

  a_out_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_edge_distance <= HY_Y)
    else $error("edge distance above 1.5");
`endif

endmodule : hex_grid_edge_distance

`default_nettype wire

@@ sim/hex_grid_edge_distance_tb.sv @@
// hex_grid_edge_distance_tb: self-checking testbench for the hexagonal edge distance pipeline.
// Depends on hged_pkg and hex_grid_edge_distance; predicts each distance in fixed point.
`timescale 1ns / 1ps

module hex_grid_edge_distance_tb;

  localparam int unsigned IN_W  = hged_pkg::IN_W;
  localparam int unsigned FRAC  = 16;
  localparam int unsigned OUT_W = FRAC + 1;
  // Cycles without any transfer before the run is declared hung. The longest
  // correct quiet stretch is the output hold-off below.
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned HOLD_OFF_CYCLES = 200;

  // Fold geometry at FRAC = 16, used to aim the stimulus at cell features.
  localparam int HALF_R3 = 56756;
  localparam int MOD_X   = 2 * HALF_R3;
  localparam int HALF_Y  = 98304;
  localparam int MOD_Y   = 2 * HALF_Y;
  localparam int COORD_MIN = -8388608;
  localparam int COORD_MAX = 8388607;

  typedef struct {
    logic [IN_W-1:0]  x;
    logic [IN_W-1:0]  y;
    logic [OUT_W-1:0] edist;
  } dist_entry_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic signed [IN_W-1:0]   in_x_coord = '0;
  logic signed [IN_W-1:0]   in_y_coord = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic        [OUT_W-1:0]  out_edge_distance;

  dist_entry_t dist_expected[$];
  int unsigned mismatch_count    = 0;
  int unsigned points_sent       = 0;
  int unsigned distances_checked = 0;
  int unsigned hold_cycles       = 0;
  bit          src_idle_on       = 1'b1;
  bit          sink_idle_on      = 1'b1;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  hex_grid_edge_distance #(
    .FRAC_BITS(FRAC)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_x_coord       (in_x_coord),
    .in_y_coord       (in_y_coord),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_edge_distance(out_edge_distance)
  );

  // ---------------------------------------------------------------------------
  // Distance predictor. Fold both coordinates into one cell, pick the nearer of
  // the two lattice centers (strict compare, ties keep the first), then take
  // either the folded y (below the 30 degree line) or the slanted edge distance
  // rounded half up. All products are exact in 64 bits.
  // ---------------------------------------------------------------------------
  function automatic logic [OUT_W-1:0] hex_edge_distance(logic [IN_W-1:0] xr,
                                                         logic [IN_W-1:0] yr);
    longint unsigned sq3, hr3, mx, my, hy;
    longint unsigned ax, ay, x1, y1, x2, y2, slant, r;
    sq3 = longint'(hged_pkg::SQRT3_Q30);
    hr3 = (sq3 + (64'd1 << (30 - FRAC))) >> (31 - FRAC);
    mx  = 2 * hr3;
    my  = 64'd3 << FRAC;
    hy  = 64'd3 << (FRAC - 1);
    // Magnitude of a 24-bit two's complement value; -2^23 maps to 2^23.
    ax = xr[IN_W-1] ? (64'd1 << IN_W) - xr : 64'(xr);
    ay = yr[IN_W-1] ? (64'd1 << IN_W) - yr : 64'(yr);
    x1 = ax % mx;
    x1 = (x1 > hr3) ? x1 - hr3 : hr3 - x1;
    y1 = ay % my;
    y1 = (y1 > hy) ? y1 - hy : hy - y1;
    x2 = hr3 - x1;
    y2 = hy - y1;
    if (x1 * x1 + y1 * y1 > x2 * x2 + y2 * y2) begin
      x1 = x2;
      y1 = y2;
    end
    if (y1 * sq3 < (x1 << 30)) begin
      r = y1;
    end else begin
      slant = ((y1 << 30) > x1 * sq3) ? (y1 << 30) - x1 * sq3 : x1 * sq3 - (y1 << 30);
      r = (slant + (64'd1 << 30)) >> 31;
    end
    if (r > hy) begin
      r = hy;
    end
    return r[OUT_W-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("ERROR %0t ns: %s", $time, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Input side. Called at a rising-edge step; returns at the edge that made the
  // transfer with in_valid still high, so a following call can keep it high
  // without a second assignment in the same step. in_ready is sampled at the
  // falling edge, where every signal feeding it is settled.
  // ---------------------------------------------------------------------------
  task automatic send_point(input logic [IN_W-1:0] x, input logic [IN_W-1:0] y);
    bit taken;
    while (src_idle_on && $urandom_range(99) < 24) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_x_coord <= x;
    in_y_coord <= y;
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    dist_expected.push_back('{x: x, y: y, edist: hex_edge_distance(x, y)});
    points_sent++;
  endtask

  // Drop valid and wait until every predicted distance has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (dist_expected.size() != 0) begin
      @(posedge clk);
    end
  endtask

  function automatic logic [IN_W-1:0] clamp_coord(int v);
    if (v < COORD_MIN) return IN_W'(COORD_MIN);
    if (v > COORD_MAX) return IN_W'(COORD_MAX);
    return IN_W'(v);
  endfunction

  // Point close to a lattice feature: a random multiple of half the fold period plus
  // a small offset, with random sign. Hits fold seams, centers and both sides
  // of the 30 degree line much more often than uniform coordinates do.
  task automatic near_lattice_point(output logic [IN_W-1:0] x, output logic [IN_W-1:0] y);
    int kx, ky;
    kx = $urandom_range(0, 2 * (COORD_MAX / MOD_X)) * HALF_R3
         + $urandom_range(0, 4096) - 2048;
    ky = $urandom_range(0, 2 * (COORD_MAX / MOD_Y)) * HALF_Y
         + $urandom_range(0, 4096) - 2048;
    x = clamp_coord($urandom_range(1) ? -kx : kx);
    y = clamp_coord($urandom_range(1) ? -ky : ky);
  endtask

  task automatic random_point(output logic [IN_W-1:0] x, output logic [IN_W-1:0] y);
    logic [31:0] rx, ry;
    int unsigned pick;
    pick = $urandom_range(99);
    rx = $urandom();
    ry = $urandom();
    if (pick < 45) begin
      x = rx[IN_W-1:0];
      y = ry[IN_W-1:0];
    end else if (pick < 90) begin
      near_lattice_point(x, y);
    end else begin
      // Tiny coordinates around the origin.
      x = IN_W'(int'($urandom_range(0, 16)) - 8);
      y = IN_W'(int'($urandom_range(0, 16)) - 8);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Extremes, wrap points, lattice centers, fold seams and the 30 degree line.
  task automatic test_directed_points();
    send_point(IN_W'(0), IN_W'(0));                         // lattice center
    send_point(IN_W'(HALF_R3), IN_W'(HALF_Y));              // other center
    send_point(IN_W'(COORD_MIN), IN_W'(COORD_MIN));         // most negative
    send_point(IN_W'(COORD_MAX), IN_W'(COORD_MAX));
    send_point(IN_W'(COORD_MIN), IN_W'(COORD_MAX));
    send_point(IN_W'(COORD_MAX), IN_W'(COORD_MIN));
    send_point(IN_W'(0), IN_W'(COORD_MIN));
    send_point(IN_W'(COORD_MIN), IN_W'(0));
    send_point(IN_W'(-1), IN_W'(-1));
    send_point(IN_W'(1), IN_W'(1));
    send_point(IN_W'(MOD_X - 1), IN_W'(MOD_Y - 1));         // just below the seams
    send_point(IN_W'(MOD_X), IN_W'(MOD_Y));                 // on the seams
    send_point(IN_W'(-MOD_X), IN_W'(-MOD_Y));
    send_point(IN_W'(HALF_R3 - 1), IN_W'(HALF_Y - 1));
    send_point(IN_W'(HALF_R3), IN_W'(0));
    send_point(IN_W'(0), IN_W'(HALF_Y));
    // Straddle the 30 degree line: sqrt(3) * 1000 = 1732.05.
    send_point(IN_W'(HALF_R3 + 1732), IN_W'(HALF_Y + 1000));
    send_point(IN_W'(HALF_R3 + 1733), IN_W'(HALF_Y + 1000));
    send_point(IN_W'(-(HALF_R3 + 1732)), IN_W'(-(HALF_Y + 1000)));
    send_point(IN_W'(HALF_R3 / 2), IN_W'(HALF_Y / 2));
    send_point(IN_W'(24'h555555), IN_W'(24'haaaaaa));       // alternating bits
    send_point(IN_W'(24'haaaaaa), IN_W'(24'h555555));
    wait_drained();
  endtask

  // Mixed random points with both sides idling at random.
  task automatic test_random_points(input int unsigned count);
    logic [IN_W-1:0] x, y;
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    repeat (count) begin
      random_point(x, y);
      send_point(x, y);
    end
  endtask

  // A long stretch at full rate on both sides.
  task automatic test_full_rate(input int unsigned count);
    logic [IN_W-1:0] x, y;
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    repeat (count) begin
      random_point(x, y);
      send_point(x, y);
    end
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering: every stage fills and
  // in_ready must fall, then the backlog drains in order.
  task automatic test_output_stall(input int unsigned count);
    logic [IN_W-1:0] x, y;
    src_idle_on = 1'b0;
    hold_cycles = HOLD_OFF_CYCLES;
    repeat (count) begin
      random_point(x, y);
      send_point(x, y);
    end
    src_idle_on = 1'b1;
    wait_drained();
  endtask

  // Sender stops until all results are back, then resumes.
  task automatic test_drained_pause(input int unsigned count);
    logic [IN_W-1:0] x, y;
    repeat (2) begin
      repeat (count) begin
        random_point(x, y);
        send_point(x, y);
      end
      wait_drained();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Output side: drives out_ready at each rising edge, samples the handshake at
  // the falling edge and checks the transfer against the oldest prediction.
  // ---------------------------------------------------------------------------
  initial begin : result_checker
    dist_entry_t want;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else begin
        out_ready <= !sink_idle_on || ($urandom_range(99) >= 24);
      end
      @(negedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (dist_expected.size() == 0) begin
          report_mismatch($sformatf("distance %0d with no point outstanding",
                                    out_edge_distance));
        end else begin
          want = dist_expected.pop_front();
          distances_checked++;
          if (out_edge_distance !== want.edist) begin
            report_mismatch($sformatf("x=%0d y=%0d: distance %0d, predicted %0d",
                                      $signed(want.x), $signed(want.y),
                                      out_edge_distance, want.edist));
          end
        end
      end
    end
  end

  // Hang detector: any cycle with a transfer on either side resets the count.
  initial begin : stall_watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(negedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("ERROR: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, dist_expected.size());
    $display("Verification failed");
    $finish;
  end

  initial begin : run_tests
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_points();
    test_random_points(450);
    test_full_rate(200);
    test_output_stall(80);
    test_drained_pause(30);
    test_random_points(150);

    wait_drained();
    // Let the pipeline run empty; any stray result is flagged by the checker.
    repeat (hged_pkg::N_STAGES + 8) @(posedge clk);

    $display("Covered %0d points: extreme, seam and lattice-center coordinates, both sides",
             points_sent);
    $display("of the 30 degree line, full-range and near-lattice random, stall and pause; %0d checked",
             distances_checked);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
